>>> rtl/core/ibrt_pkg.sv
// Shared types and constants of the tile refinement test block.
package ibrt_pkg;

  localparam int VAL_W      = 32;
  localparam int CUT_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int NUM_TESTS  = 5;
  localparam int BS_W       = 6;
  localparam int EN_W       = 5;
  localparam int FRACS_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int WORD_W     = 33;
  localparam int SUM_W      = 35;
  localparam int SQ_IN_W    = 36;
  localparam int SQ_HALF_W  = 18;
  localparam int SQ_OUT_W   = 72;
  localparam int DIV_NUM_W  = 54;
  localparam int DIV_DEN_W  = 34;
  localparam int Q_W        = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TEST_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_GRAD_CUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_GRAD_CUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_LAPL_CUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_LAPL_CUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION     = 3'd7;

  typedef struct packed {
    logic [EN_W-1:0]    test_enable;
    logic [BS_W-1:0]    block_size;
    logic [CUT_W-1:0]   value_cut;
    logic [CUT_W-1:0]   abs_grad_cut;
    logic [CUT_W-1:0]   rel_grad_cut;
    logic [CUT_W-1:0]   abs_lapl_cut;
    logic [CUT_W-1:0]   rel_lapl_cut;
    logic [FRACS_W-1:0] fraction_pack;
  } cfg_t;

  typedef enum logic [2:0] {
    CS_LOAD, CS_ISSUE, CS_WAIT, CS_READ, CS_PREP, CS_COUNT, CS_FINAL, CS_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_CUT_GRAD, OP_CUT_REL, OP_SQ_GX, OP_SQ_GY, OP_DIV_QX,
    OP_DIV_QY, OP_SQ_QX, OP_SQ_QY, OP_DIV_LX, OP_DIV_LY
  } op_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] x;
  } sq_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] prod;
  } sq_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/ibrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ibrt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ibrt_sqr.sv
// Multi-cycle squarer built from four 18x18 partial products.
module ibrt_sqr import ibrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  sq_req_t req,
  output sq_rsp_t rsp
);

  logic                 busy;
  logic [1:0]           ph;
  logic [SQ_IN_W-1:0]   xr;
  logic [SQ_OUT_W-1:0]  acc;
  logic [SQ_HALF_W-1:0] op_a;
  logic [SQ_HALF_W-1:0] op_b;
  logic [SQ_IN_W-1:0]   pp;
  logic [SQ_OUT_W-1:0]  pp_shift;

  assign op_a = ph[1] ? xr[SQ_IN_W-1:SQ_HALF_W] : xr[SQ_HALF_W-1:0];
  assign op_b = ph[0] ? xr[SQ_IN_W-1:SQ_HALF_W] : xr[SQ_HALF_W-1:0];
  assign pp   = SQ_IN_W'(op_a) * SQ_IN_W'(op_b);

  always_comb begin
    case (ph)
      2'd0:    pp_shift = SQ_OUT_W'(pp);
      2'd3:    pp_shift = SQ_OUT_W'(pp) << (2 * SQ_HALF_W);
      default: pp_shift = SQ_OUT_W'(pp) << SQ_HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      ph       <= 2'd0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        ph   <= 2'd0;
      end else if (busy) begin
        ph <= ph + 2'd1;
        if (ph == 2'd3) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xr  <= req.x;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_shift;
    end
  end

  assign rsp.prod = acc;

endmodule

>>> rtl/core/ibrt_div.sv
// Radix-2 restoring divider with a 32-bit quotient that saturates on overflow.
module ibrt_div import ibrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int REM_W = DIV_DEN_W + 1;

  logic                 busy;
  logic [4:0]           cnt;
  logic                 sat;
  logic [REM_W-1:0]     rem;
  logic [Q_W-1:0]       nlo;
  logic [Q_W-1:0]       q;
  logic [DIV_DEN_W-1:0] den;
  logic [REM_W-1:0]     trial;
  logic                 ge;

  assign trial = {rem[REM_W-2:0], nlo[Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.den;
      sat <= (req.den == '0) ||
             (DIV_DEN_W'(req.num[DIV_NUM_W-1:Q_W]) >= req.den);
      rem <= REM_W'(req.num[DIV_NUM_W-1:Q_W]);
      nlo <= req.num[Q_W-1:0];
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, den} : trial;
      nlo <= {nlo[Q_W-2:0], 1'b0};
      q   <= {q[Q_W-2:0], ge};
    end
  end

  assign rsp.quot = sat ? {Q_W{1'b1}} : q;

endmodule

>>> rtl/core/ibrt_ctrl.sv
// Tile loader, stencil sequencer and per-test counters of the refinement test.
module ibrt_ctrl import ibrt_pkg::*; #(
  parameter int MAX_TILE_EDGE = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  cfg_t                                         cfg,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic signed [VAL_W-1:0]                      intensity,
  input  logic                                         sample_bad,
  input  logic                                         last_pixel,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic                                         refine,
  output logic                                         ram_we,
  output logic [$clog2(MAX_TILE_EDGE*MAX_TILE_EDGE)-1:0] ram_waddr,
  output logic [WORD_W-1:0]                            ram_wdata,
  output logic [$clog2(MAX_TILE_EDGE*MAX_TILE_EDGE)-1:0] ram_raddr,
  input  logic [WORD_W-1:0]                            ram_rdata,
  output sq_req_t                                      sq_req,
  input  sq_rsp_t                                      sq_rsp,
  output div_req_t                                     div_req,
  input  div_rsp_t                                     div_rsp
);

  localparam int DEPTH   = MAX_TILE_EDGE * MAX_TILE_EDGE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RC_W    = $clog2(MAX_TILE_EDGE);
  localparam int N_W     = $clog2(MAX_TILE_EDGE + 1);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CNT_N   = 2 * NUM_TESTS;
  localparam int RD_N    = 5;
  localparam int RD_W    = $clog2(RD_N + 1);
  localparam int K_W     = $clog2(NUM_TESTS);
  localparam int CMP_W   = CNT_W + FRAC_W;

  ctrl_state_t state, state_next;
  op_t         step, step_after;

  logic [ADDR_W-1:0] load_pos;
  logic [N_W-1:0]    n;
  logic [RC_W-1:0]   n_last;
  logic [ADDR_W-1:0] n_ext;
  logic [RC_W-1:0]   r, c;
  logic [ADDR_W-1:0] rowbase, maddr;
  logic [ADDR_W-1:0] rd_addr [RD_N];
  logic [RD_W-1:0]   rd_idx;
  logic [WORD_W-1:0] words [RD_N];
  logic              xe, ye, last_point;

  logic signed [SUM_W-1:0] ax, bx, ay, by, mv;
  logic signed [SUM_W-1:0] diff_x, diff_y, dsx, dsy, lx, ly;
  logic [VAL_W-1:0]        m_val;
  logic                    bad_g, bad_m;

  logic [SQ_OUT_W-1:0] cut2_g, cut2_r, acc;
  logic                hit2, hit3;
  logic [Q_W-1:0]      qx, qy, pxq, pyq;
  logic [CNT_W-1:0]    cnt [CNT_N];
  logic [K_W-1:0]      k;
  logic                refine_acc;
  logic                unit_done, op_is_div;

  function automatic logic signed [SUM_W-1:0] sx(input logic [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? ~v + 1'b1 : v;
  endfunction

  always_comb begin
    if (cfg.block_size < BS_W'(3)) begin
      n = N_W'(3);
    end else if (int'(cfg.block_size) > MAX_TILE_EDGE) begin
      n = N_W'(MAX_TILE_EDGE);
    end else begin
      n = N_W'(cfg.block_size);
    end
  end

  assign n_last     = RC_W'(n - N_W'(1));
  assign n_ext      = ADDR_W'(n);
  assign maddr      = rowbase + ADDR_W'(c);
  assign xe         = (c == '0) || (c == n_last);
  assign ye         = (r == '0) || (r == n_last);
  assign last_point = (c == n_last) && (r == n_last);

  assign rd_addr[0] = maddr;
  assign rd_addr[1] = (c == '0) ? maddr : maddr - ADDR_W'(1);
  assign rd_addr[2] = (c == n_last) ? maddr : maddr + ADDR_W'(1);
  assign rd_addr[3] = (r == '0) ? maddr : maddr - n_ext;
  assign rd_addr[4] = (r == n_last) ? maddr : maddr + n_ext;

  assign mv = sx(words[0][VAL_W-1:0]);
  assign ax = sx(words[1][VAL_W-1:0]);
  assign bx = sx(words[2][VAL_W-1:0]);
  assign ay = sx(words[3][VAL_W-1:0]);
  assign by = sx(words[4][VAL_W-1:0]);

  // Operands for the shared squarer and divider.
  logic [SUM_W-1:0] gx_mag, gy_mag, g2x_mag, g2y_mag, dx_mag, dy_mag, lx_mag, ly_mag;

  assign gx_mag  = mag(xe ? diff_x <<< 1 : diff_x);
  assign gy_mag  = mag(ye ? diff_y <<< 1 : diff_y);
  assign g2x_mag = mag(diff_x <<< 1);
  assign g2y_mag = mag(diff_y <<< 1);
  assign dx_mag  = mag(dsx);
  assign dy_mag  = mag(dsy);
  assign lx_mag  = mag(lx);
  assign ly_mag  = mag(ly);

  always_comb begin
    case (step)
      OP_CUT_GRAD: step_after = OP_CUT_REL;
      OP_CUT_REL:  step_after = OP_SQ_GX;
      OP_SQ_GX:    step_after = OP_SQ_GY;
      OP_SQ_GY:    step_after = OP_DIV_QX;
      OP_DIV_QX:   step_after = OP_DIV_QY;
      OP_DIV_QY:   step_after = OP_SQ_QX;
      OP_SQ_QX:    step_after = OP_SQ_QY;
      OP_SQ_QY:    step_after = OP_DIV_LX;
      OP_DIV_LX:   step_after = OP_DIV_LY;
      default:     step_after = OP_SQ_GX;
    endcase
  end

  assign op_is_div = (step == OP_DIV_QX) || (step == OP_DIV_QY) ||
                     (step == OP_DIV_LX) || (step == OP_DIV_LY);
  assign unit_done = op_is_div ? div_rsp.done : sq_rsp.done;

  always_comb begin
    state_next = state;
    case (state)
      CS_LOAD: begin
        if (in_valid && last_pixel) begin
          state_next = CS_ISSUE;
        end
      end
      CS_ISSUE: state_next = CS_WAIT;
      CS_WAIT: begin
        if (unit_done) begin
          if (step == OP_CUT_REL) begin
            state_next = CS_READ;
          end else if (step == OP_DIV_LY) begin
            state_next = CS_COUNT;
          end else begin
            state_next = CS_ISSUE;
          end
        end
      end
      CS_READ: begin
        if (rd_idx == RD_W'(RD_N)) begin
          state_next = CS_PREP;
        end
      end
      CS_PREP: state_next = CS_ISSUE;
      CS_COUNT: state_next = last_point ? CS_FINAL : CS_READ;
      CS_FINAL: begin
        if (k == K_W'(NUM_TESTS - 1)) begin
          state_next = CS_OUT;
        end
      end
      CS_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = CS_LOAD;
        end
      end
      default: state_next = CS_LOAD;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    ram_we       = 1'b0;
    ram_waddr    = load_pos;
    ram_wdata    = {sample_bad, intensity};
    ram_raddr    = maddr;
    sq_req.start = 1'b0;
    sq_req.x     = '0;
    div_req.start = 1'b0;
    div_req.num  = '0;
    div_req.den  = '0;
    case (state)
      CS_LOAD: begin
        in_stall = 1'b0;
        ram_we   = in_valid;
      end
      CS_READ: begin
        if (rd_idx != RD_W'(RD_N)) begin
          ram_raddr = rd_addr[rd_idx];
        end
      end
      CS_ISSUE: begin
        sq_req.start  = !op_is_div;
        div_req.start = op_is_div;
        case (step)
          OP_CUT_GRAD: sq_req.x = SQ_IN_W'({cfg.abs_grad_cut, 1'b0});
          OP_CUT_REL:  sq_req.x = SQ_IN_W'(cfg.rel_grad_cut);
          OP_SQ_GX:    sq_req.x = SQ_IN_W'(gx_mag);
          OP_SQ_GY:    sq_req.x = SQ_IN_W'(gy_mag);
          OP_SQ_QX:    sq_req.x = SQ_IN_W'(qx);
          OP_SQ_QY:    sq_req.x = SQ_IN_W'(qy);
          OP_DIV_QX: begin
            div_req.num = DIV_NUM_W'({g2x_mag[DIV_DEN_W-1:0], 16'b0});
            div_req.den = dx_mag[DIV_DEN_W-1:0];
          end
          OP_DIV_QY: begin
            div_req.num = DIV_NUM_W'({g2y_mag[DIV_DEN_W-1:0], 16'b0});
            div_req.den = dy_mag[DIV_DEN_W-1:0];
          end
          OP_DIV_LX: begin
            div_req.num = DIV_NUM_W'({lx_mag[DIV_DEN_W-1:0], 18'b0});
            div_req.den = dx_mag[DIV_DEN_W-1:0];
          end
          OP_DIV_LY: begin
            div_req.num = DIV_NUM_W'({ly_mag[DIV_DEN_W-1:0], 18'b0});
            div_req.den = dy_mag[DIV_DEN_W-1:0];
          end
          default: sq_req.x = '0;
        endcase
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Per-point test evaluation.
  logic [VAL_W:0]          m33, m_mag;
  logic                    hit1, hit4, hit5, dnz;
  logic [SUM_W:0]          lap, lap_mag;
  logic signed [Q_W:0]     px, py;
  logic [Q_W+1:0]          psum, psum_mag;
  logic [CNT_N-1:0]        inc;
  logic [SQ_OUT_W:0]       sq_sum;
  logic [CNT_W-1:0]        exam, exc;
  logic [CMP_W-1:0]        lhs, rhs;
  logic [FRAC_W-1:0]       frac;

  assign m33     = {m_val[VAL_W-1], m_val};
  assign m_mag   = m33[VAL_W] ? ~m33 + 1'b1 : m33;
  assign hit1    = m_mag > {1'b0, cfg.value_cut};
  assign lap     = {lx[SUM_W-1], lx} + {ly[SUM_W-1], ly};
  assign lap_mag = lap[SUM_W] ? ~lap + 1'b1 : lap;
  assign hit4    = lap_mag > (SUM_W + 1)'(cfg.abs_lapl_cut);
  assign px      = (lx[SUM_W-1] != dsx[SUM_W-1]) ? -$signed({1'b0, pxq}) : $signed({1'b0, pxq});
  assign py      = (ly[SUM_W-1] != dsy[SUM_W-1]) ? -$signed({1'b0, pyq}) : $signed({1'b0, pyq});
  assign psum    = {px[Q_W], px} + {py[Q_W], py};
  assign psum_mag = psum[Q_W+1] ? ~psum + 1'b1 : psum;
  assign hit5    = psum_mag > (Q_W + 2)'(cfg.rel_lapl_cut);
  assign dnz     = (dsx != '0) && (dsy != '0);
  assign sq_sum  = {1'b0, acc} + {1'b0, sq_rsp.prod};

  always_comb begin
    inc[0] = !bad_m;
    inc[1] = !bad_m && hit1;
    inc[2] = !bad_g;
    inc[3] = !bad_g && hit2;
    inc[4] = !bad_g && !((!xe || !ye) && bad_m) && dnz;
    inc[5] = inc[4] && hit3;
    inc[6] = !xe && !ye && !bad_g && !bad_m;
    inc[7] = inc[6] && hit4;
    inc[8] = inc[6] && dnz;
    inc[9] = inc[8] && hit5;
  end

  assign exam = cnt[{k, 1'b0}];
  assign exc  = cnt[{k, 1'b1}];
  assign frac = cfg.fraction_pack[{k, 3'b0} +: FRAC_W];
  assign lhs  = {exc, {FRAC_W{1'b0}}};
  assign rhs  = CMP_W'(frac) * CMP_W'(exam);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_LOAD;
      load_pos  <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
      step      <= OP_CUT_GRAD;
      k         <= '0;
      r         <= '0;
      c         <= '0;
      rowbase   <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != CS_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        CS_LOAD: begin
          if (in_valid) begin
            if (last_pixel) begin
              load_pos <= '0;
            end else if (load_pos == ADDR_W'(DEPTH - 1)) begin
              load_pos <= '0;
            end else begin
              load_pos <= load_pos + ADDR_W'(1);
            end
          end
          step    <= OP_CUT_GRAD;
          k       <= '0;
          r       <= '0;
          c       <= '0;
          rowbase <= '0;
          rd_idx  <= '0;
        end
        CS_WAIT: begin
          if (unit_done) begin
            step <= step_after;
          end
        end
        CS_READ: begin
          rd_idx <= (rd_idx == RD_W'(RD_N)) ? '0 : rd_idx + RD_W'(1);
        end
        CS_COUNT: begin
          if (c == n_last) begin
            c       <= '0;
            r       <= r + RC_W'(1);
            rowbase <= rowbase + n_ext;
          end else begin
            c <= c + RC_W'(1);
          end
        end
        CS_FINAL: begin
          k <= k + K_W'(1);
        end
        CS_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
          end
        end
        default: k <= k;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_LOAD: begin
        for (int i = 0; i < CNT_N; i++) begin
          cnt[i] <= '0;
        end
        refine_acc <= 1'b0;
      end
      CS_READ: begin
        if (rd_idx != '0) begin
          words[rd_idx - RD_W'(1)] <= ram_rdata;
        end
      end
      CS_PREP: begin
        diff_x <= bx - ax;
        diff_y <= by - ay;
        dsx    <= xe ? ax + bx : ax + (mv <<< 1) + bx;
        dsy    <= ye ? ay + by : ay + (mv <<< 1) + by;
        lx     <= ax - (mv <<< 1) + bx;
        ly     <= ay - (mv <<< 1) + by;
        m_val  <= words[0][VAL_W-1:0];
        bad_m  <= words[0][WORD_W-1];
        bad_g  <= words[1][WORD_W-1] | words[2][WORD_W-1] |
                  words[3][WORD_W-1] | words[4][WORD_W-1];
      end
      CS_WAIT: begin
        if (unit_done) begin
          case (step)
            OP_CUT_GRAD: cut2_g <= sq_rsp.prod;
            OP_CUT_REL:  cut2_r <= sq_rsp.prod;
            OP_SQ_GX:    acc    <= sq_rsp.prod;
            OP_SQ_GY:    hit2   <= sq_sum > {1'b0, cut2_g};
            OP_DIV_QX:   qx     <= div_rsp.quot;
            OP_DIV_QY:   qy     <= div_rsp.quot;
            OP_SQ_QX:    acc    <= sq_rsp.prod;
            OP_SQ_QY:    hit3   <= sq_sum > {1'b0, cut2_r};
            OP_DIV_LX:   pxq    <= div_rsp.quot;
            default:     pyq    <= div_rsp.quot;
          endcase
        end
      end
      CS_COUNT: begin
        for (int i = 0; i < CNT_N; i++) begin
          cnt[i] <= cnt[i] + CNT_W'(inc[i]);
        end
      end
      CS_FINAL: begin
        if (cfg.test_enable[k] && (lhs > rhs)) begin
          refine_acc <= 1'b1;
        end
      end
      CS_OUT: begin
        if (!out_valid || !out_stall) begin
          refine <= refine_acc;
        end
      end
      default: refine_acc <= refine_acc;
    endcase
  end

endmodule

>>> rtl/core/image_block_refinement_test.sv
// Top level of the tile refinement test: configuration registers, tile RAM and arithmetic units.
// Pixels load at one per cycle while in_stall is low; the last pixel of a tile starts an evaluation.
// Evaluation time grows with tile edge n and is set by the single RAM read port
// (five reads per point) and the shared divider (four quotients per point).
// Synchronous active-high reset clears control state and loads register defaults.
module image_block_refinement_test import ibrt_pkg::*; #(
  parameter int MAX_TILE_EDGE = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] intensity,
  input  logic                    sample_bad,
  input  logic                    last_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    refine,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH  = MAX_TILE_EDGE * MAX_TILE_EDGE;
  localparam int ADDR_W = $clog2(DEPTH);

  cfg_t              cfg;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  sq_req_t           sq_req;
  sq_rsp_t           sq_rsp;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.test_enable   <= '0;
      cfg.block_size    <= BS_W'(8);
      cfg.value_cut     <= '0;
      cfg.abs_grad_cut  <= '0;
      cfg.rel_grad_cut  <= '0;
      cfg.abs_lapl_cut  <= '0;
      cfg.rel_lapl_cut  <= '0;
      cfg.fraction_pack <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEST_ENABLE:  cfg.test_enable   <= cfg_data[EN_W-1:0];
        CFG_BLOCK_SIZE:   cfg.block_size    <= cfg_data[BS_W-1:0];
        CFG_VALUE_CUT:    cfg.value_cut     <= cfg_data[CUT_W-1:0];
        CFG_ABS_GRAD_CUT: cfg.abs_grad_cut  <= cfg_data[CUT_W-1:0];
        CFG_REL_GRAD_CUT: cfg.rel_grad_cut  <= cfg_data[CUT_W-1:0];
        CFG_ABS_LAPL_CUT: cfg.abs_lapl_cut  <= cfg_data[CUT_W-1:0];
        CFG_REL_LAPL_CUT: cfg.rel_lapl_cut  <= cfg_data[CUT_W-1:0];
        CFG_FRACTION:     cfg.fraction_pack <= cfg_data[FRACS_W-1:0];
        default:          cfg.test_enable   <= cfg.test_enable;
      endcase
    end
  end

  ibrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ibrt_sqr u_sqr (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  ibrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ibrt_ctrl #(
    .MAX_TILE_EDGE (MAX_TILE_EDGE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .intensity  (intensity),
    .sample_bad (sample_bad),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .refine     (refine),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .sq_req     (sq_req),
    .sq_rsp     (sq_rsp),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

endmodule

>>> rtl/core/ibrt_check.sv
// Port-level assertions for the tile refinement test, bound to the top level.
module ibrt_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last_pixel,
  input logic out_valid,
  input logic out_stall,
  input logic refine
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(refine))
    else $error("result beat changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_pixel |=> in_stall)
    else $error("input not stalled after last pixel of a tile");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared without an evaluation");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind image_block_refinement_test ibrt_check u_ibrt_check (.*);

>>> bench/image_block_refinement_test_tb.sv
// Self-checking testbench for the tile refinement test block.
`timescale 1ns / 100ps

module image_block_refinement_test_tb;
  import ibrt_pkg::*;

  localparam int EDGE_MAX = 32;
  localparam int STORE_N = EDGE_MAX * EDGE_MAX;
  localparam int ITEM_GOAL = 1550;

  typedef enum int {PIX_SMOOTH, PIX_WILD, PIX_EXTREME, PIX_TINY} pix_mode_t;

  logic clk = 0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [VAL_W-1:0] intensity;
  logic sample_bad;
  logic last_pixel;
  logic out_valid;
  logic out_stall;
  logic refine;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  image_block_refinement_test #(.MAX_TILE_EDGE(EDGE_MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .intensity(intensity), .sample_bad(sample_bad), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .refine(refine),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Mirror of the block's registers and tile memory.
  bit [EN_W-1:0] enable_cfg;
  bit [BS_W-1:0] edge_cfg;
  bit [31:0] cut_cfg [5];
  bit [FRACS_W-1:0] fraction_cfg;
  bit [32:0] tile_word [STORE_N];
  bit written [STORE_N];
  int load_pos;

  bit refine_due [$];
  int failures;
  int items_sent;
  int hold_left;
  bit stall_idle_on;
  bit send_idle_on;

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint sat_quot(longint num, longint den);
    longint q;
    q = num / den;
    return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic bit [127:0] square(longint x);
    bit [127:0] w;
    w = 128'(x);
    return w * w;
  endfunction

  function automatic longint word_value(bit [32:0] w);
    return longint'($signed(w[31:0]));
  endfunction

  function automatic void fetch_axis(int n, int r, int c, bit vertical,
                                     output longint a, output longint m, output longint b,
                                     output bit bad_ab, output bit bad_m, output bit on_rim);
    int p, ar, ac, br, bc;
    bit [32:0] wa, wb, wm;
    p = vertical ? r : c;
    ar = r; ac = c; br = r; bc = c;
    on_rim = (p == 0 || p == n - 1);
    if (p == 0) begin
      if (vertical) br = r + 1; else bc = c + 1;
    end else if (p == n - 1) begin
      if (vertical) ar = r - 1; else ac = c - 1;
    end else begin
      if (vertical) begin ar = r - 1; br = r + 1; end
      else begin ac = c - 1; bc = c + 1; end
    end
    wa = tile_word[(ar * n + ac) % STORE_N];
    wb = tile_word[(br * n + bc) % STORE_N];
    wm = tile_word[(r * n + c) % STORE_N];
    a = word_value(wa);
    b = word_value(wb);
    m = word_value(wm);
    bad_ab = wa[32] | wb[32];
    bad_m = wm[32];
  endfunction

  function automatic longint rel_lapl_share(longint a, longint m, longint b);
    longint num, den, q;
    num = a - 2 * m + b;
    den = a + 2 * m + b;
    q = sat_quot((mag(num) * 4) << 16, mag(den));
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic int tile_edge();
    return edge_cfg < 3 ? 3 : (edge_cfg > EDGE_MAX ? EDGE_MAX : int'(edge_cfg));
  endfunction

  function automatic bit predict_refine();
    int n;
    longint cnt [10];
    longint xa, xm, xb, ya, ym, yb, dx, dy, lap, gx, gy, qx, qy, frac;
    bit xbad_ab, xbad_m, xrim, ybad_ab, ybad_m, yrim, bad_g, flag;
    n = tile_edge();
    flag = 0;
    foreach (cnt[i]) cnt[i] = 0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        fetch_axis(n, r, c, 0, xa, xm, xb, xbad_ab, xbad_m, xrim);
        fetch_axis(n, r, c, 1, ya, ym, yb, ybad_ab, ybad_m, yrim);
        bad_g = xbad_ab || ybad_ab;
        if (!xbad_m) begin
          cnt[0]++;
          if (mag(xm) > cut_cfg[0]) cnt[1]++;
        end
        if (!bad_g) begin
          gx = xrim ? mag(2 * (xb - xa)) : mag(xb - xa);
          gy = yrim ? mag(2 * (yb - ya)) : mag(yb - ya);
          cnt[2]++;
          if (square(gx) + square(gy) > square(2 * longint'(cut_cfg[1]))) cnt[3]++;
        end
        if (!bad_g && !((!xrim || !yrim) && xbad_m)) begin
          dx = xrim ? xa + xb : xa + 2 * xm + xb;
          dy = yrim ? ya + yb : ya + 2 * ym + yb;
          if (dx != 0 && dy != 0) begin
            qx = sat_quot(mag(2 * (xb - xa)) << 16, mag(dx));
            qy = sat_quot(mag(2 * (yb - ya)) << 16, mag(dy));
            cnt[4]++;
            if (square(qx) + square(qy) > square(longint'(cut_cfg[2]))) cnt[5]++;
          end
        end
        if (!xrim && !yrim && !bad_g && !xbad_m) begin
          lap = (xa - 2 * xm + xb) + (ya - 2 * ym + yb);
          dx = xa + 2 * xm + xb;
          dy = ya + 2 * ym + yb;
          cnt[6]++;
          if (mag(lap) > cut_cfg[3]) cnt[7]++;
          if (dx != 0 && dy != 0) begin
            cnt[8]++;
            if (mag(rel_lapl_share(xa, xm, xb) + rel_lapl_share(ya, ym, yb)) > cut_cfg[4])
              cnt[9]++;
          end
        end
      end
    end
    for (int k = 0; k < 5; k++) begin
      frac = longint'((fraction_cfg >> (8 * k)) & 40'hFF);
      if (enable_cfg[k] && cnt[2 * k + 1] * 256 > frac * cnt[2 * k]) flag = 1;
    end
    return flag;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(bit [EN_W-1:0] en, bit [BS_W-1:0] bs,
                                bit [31:0] c0, bit [31:0] c1, bit [31:0] c2,
                                bit [31:0] c3, bit [31:0] c4, bit [FRACS_W-1:0] fr);
    write_reg(CFG_TEST_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
    write_reg(CFG_VALUE_CUT, CFG_DATA_W'(c0));
    write_reg(CFG_ABS_GRAD_CUT, CFG_DATA_W'(c1));
    write_reg(CFG_REL_GRAD_CUT, CFG_DATA_W'(c2));
    write_reg(CFG_ABS_LAPL_CUT, CFG_DATA_W'(c3));
    write_reg(CFG_REL_LAPL_CUT, CFG_DATA_W'(c4));
    write_reg(CFG_FRACTION, CFG_DATA_W'(fr));
    cfg_write <= 0;
    enable_cfg = en;
    edge_cfg = bs;
    cut_cfg = '{c0, c1, c2, c3, c4};
    fraction_cfg = fr;
    @(posedge clk);
  endtask

  task automatic send_pixel(bit [31:0] value, bit bad, bit last);
    while (send_idle_on && $urandom_range(99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    intensity <= value;
    sample_bad <= bad;
    last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tile_word[load_pos] = {bad, value};
    written[load_pos] = 1;
    load_pos = (load_pos + 1) % STORE_N;
    items_sent++;
    if (last) begin
      refine_due.push_back(predict_refine());
      load_pos = 0;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (refine_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic bit [31:0] pixel_value(pix_mode_t mode, int base);
    case (mode)
      PIX_SMOOTH: return base + int'($urandom_range(0, 4095)) - 2048;
      PIX_WILD: return $urandom;
      PIX_EXTREME: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return 32'h0;
        endcase
      end
      default: return int'($urandom_range(0, 2)) - 1;
    endcase
  endfunction

  function automatic bit [31:0] pick_cut();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic bit [FRACS_W-1:0] pick_fraction();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one tile; short tiles only when every examined entry was written before.
  task automatic send_tile(pix_mode_t mode, int bad_pct);
    int n, len, base, roll;
    bit covered;
    n = tile_edge();
    covered = 1;
    for (int i = 0; i < n * n; i++) if (!written[i]) covered = 0;
    len = n * n;
    roll = $urandom_range(9);
    if (covered && roll == 0) len = n * n - $urandom_range(1, n);
    else if (roll == 1) len = n * n + $urandom_range(1, n);
    base = $urandom;
    if ($urandom_range(1)) base = base >>> 8;
    for (int i = 0; i < len; i++)
      send_pixel(pixel_value(mode, base), $urandom_range(99) < bad_pct, i == len - 1);
  endtask

  task automatic test_extremes();
    bit [31:0] vals [9];
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001};
    apply_settings(5'h1F, 6'd2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 40'h0);
    foreach (vals[i]) send_pixel(vals[i], 0, i == 8);
    wait_idle();
  endtask

  task automatic test_zero_and_bad();
    apply_settings(5'h1F, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    for (int i = 0; i < 9; i++) send_pixel(32'h0, i == 4 || i == 7, i == 8);
    wait_idle();
  endtask

  task automatic test_short_tile();
    apply_settings(5'h15, 6'd0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 32'h0,
                   40'h80_40_20_10_08);
    for (int i = 0; i < 7; i++)
      send_pixel(pixel_value(PIX_SMOOTH, 32'h0010_0000), 0, i == 6);
    wait_idle();
  endtask

  task automatic test_largest_tile();
    apply_settings(5'h1F, 6'd63, pick_cut(), pick_cut(), pick_cut(), pick_cut(),
                   pick_cut(), {$urandom, $urandom});
    send_tile(PIX_SMOOTH, 2);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    apply_settings(5'h1F, 6'd3, pick_cut(), pick_cut(), pick_cut(), pick_cut(),
                   pick_cut(), pick_fraction());
    hold_left = 20000;
    for (int t = 0; t < 8; t++) send_tile(PIX_SMOOTH, 5);
    wait_idle();
  endtask

  task automatic test_random_tiles();
    int phase, bs;
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(9))
        0: bs = $urandom_range(0, 2);
        1: bs = 5;
        2: bs = 4;
        3: bs = ($urandom_range(3) == 0) ? 8 : 3;
        default: bs = 3;
      endcase
      send_idle_on = (phase % 4 != 1);
      stall_idle_on = (phase % 4 != 1);
      apply_settings($urandom_range(3) == 0 ? 5'h1F : 5'($urandom),
                     6'(bs), pick_cut(), pick_cut(), pick_cut(), pick_cut(), pick_cut(),
                     pick_fraction());
      for (int t = 0; t < 6; t++)
        send_tile(pix_mode_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? 0 : 8);
      wait_idle();
      phase++;
    end
    send_idle_on = 1;
    stall_idle_on = 1;
  endtask

  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else begin
        out_stall <= stall_idle_on && ($urandom_range(99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (refine_due.size() == 0) begin
        $error("refine beat with no result expected, actual %0b", refine);
        failures++;
      end else if (refine !== refine_due[0]) begin
        $error("refine mismatch: expected %0b, actual %0b", refine_due[0], refine);
        failures++;
        void'(refine_due.pop_front());
      end else begin
        void'(refine_due.pop_front());
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1;
    in_valid = 0;
    intensity = 0;
    sample_bad = 0;
    last_pixel = 0;
    cfg_write = 0;
    cfg_index = CFG_TEST_ENABLE;
    cfg_data = 0;
    failures = 0;
    items_sent = 0;
    hold_left = 0;
    load_pos = 0;
    send_idle_on = 1;
    stall_idle_on = 1;
    foreach (written[i]) written[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_zero_and_bad();
    test_short_tile();
    test_output_backpressure();
    test_largest_tile();
    test_random_tiles();
    wait_idle();
    repeat (200) @(posedge clk);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ibrt_pkg.sv
rtl/core/ibrt_ram.sv
rtl/core/ibrt_sqr.sv
rtl/core/ibrt_div.sv
rtl/core/ibrt_ctrl.sv
rtl/core/image_block_refinement_test.sv
rtl/core/ibrt_check.sv
bench/image_block_refinement_test_tb.sv
